@@ rtl/core/ivec_pkg.sv @@
// Shared types and constants for the indexed integer vector engine.
// Holds opcodes, status codes, controller states and the command and
// status structs passed between the controller and the datapath.
package ivec_pkg;

	// Default sizing for the top-level parameters
	localparam int DEPTH_DEF  = 1024;
	localparam int DATA_W_DEF = 32;

	// Fixed port widths
	localparam int OPCODE_W = 3;
	localparam int IDX_W    = 10;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int CAP_W    = 11;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_INSERT = 3'd4,
		OP_REMOVE = 3'd5
	} ivec_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADIDX = 2'd3
	} ivec_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RDCAP,
		S_SHIFT,
		S_DRAIN,
		S_FIN,
		S_DONE
	} ivec_state_t;

	// Read address source for single reads
	typedef enum logic {
		RD_TOP,
		RD_IDX
	} ivec_rd_sel_t;

	// Write address and data source
	typedef enum logic [1:0] {
		WR_TOP,
		WR_IDX,
		WR_LAST
	} ivec_wr_sel_t;

	// Shift pointer start
	typedef enum logic {
		PTR_TOP,
		PTR_NEXT
	} ivec_ptr_sel_t;

	typedef struct packed {
		logic          load;
		logic          stat_en;
		logic          rd_en;
		ivec_rd_sel_t  rd_sel;
		logic          wr_en;
		ivec_wr_sel_t  wr_sel;
		logic          ptr_init;
		ivec_ptr_sel_t ptr_sel;
		logic          shift;
		logic          rd_cap;
		logic          cnt_inc;
		logic          cnt_dec;
		logic          out_load;
	} ivec_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                fail;
		logic                shift_last;
		logic                rem_none;
		logic                out_free;
	} ivec_sts_t;

endpackage

@@ rtl/core/indexed_int_vector_engine.sv @@
// Indexed integer vector engine: a bounded array of signed words with
// push, pop, get, set, insert and remove. Top level joining ivec_ctrl and
// ivec_datapath. Depends on ivec_pkg.
//
// Usage:
//   Requests enter on in_valid/in_ready with opcode, index and value; one
//   result per request leaves on out_valid/out_ready with status, read_value
//   and item_count. Requests are handled one at a time.
//   The next request is taken the cycle after the result is loaded. The
//   longest request is a remove at index zero of a full array; its length
//   is set by the shift loop, which moves one entry per cycle through the
//   single write port of the element memory.
//   A finished result waits in an output register; while the receiver
//   stalls, the next request is still taken and worked through, then the
//   block holds in its done state and takes no further request.
//   Reset empties the array (count zero) and sets capacity to 1024; the
//   memory contents are left as they are. No clearing pass is needed.
//   Capacity is written through cfg_we/cfg_wdata; the user must write it
//   only while the block is idle. The block itself does not enforce this.
module indexed_int_vector_engine #(
	parameter int DEPTH      = ivec_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ivec_pkg::DATA_W_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [ivec_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [ivec_pkg::OPCODE_W-1:0] opcode,
	input  logic        [ivec_pkg::IDX_W-1:0]    index,
	input  logic signed [ivec_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [ivec_pkg::STATUS_W-1:0] status,
	output logic signed [ivec_pkg::VALUE_W-1:0]  read_value,
	output logic        [ivec_pkg::COUNT_W-1:0]  item_count
);

	ivec_pkg::ivec_cmd_t cmd;
	ivec_pkg::ivec_sts_t sts;

	// Sequencer
	ivec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and result path
	ivec_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.opcode     (opcode),
		.index      (index),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.item_count (item_count)
	);

endmodule

@@ rtl/core/ivec_datapath.sv @@
// Datapath of the indexed integer vector engine: request registers,
// element memory, entry count, shift pointer and result register.
// Depends on ivec_pkg; driven by commands from ivec_ctrl.
module ivec_datapath #(
	parameter int DEPTH      = ivec_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ivec_pkg::DATA_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic        [ivec_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic        [ivec_pkg::OPCODE_W-1:0] opcode,
	input  logic        [ivec_pkg::IDX_W-1:0]   index,
	input  logic signed [ivec_pkg::VALUE_W-1:0] value,
	input  ivec_pkg::ivec_cmd_t                 cmd,
	output ivec_pkg::ivec_sts_t                 sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [ivec_pkg::STATUS_W-1:0] status,
	output logic signed [ivec_pkg::VALUE_W-1:0] read_value,
	output logic        [ivec_pkg::COUNT_W-1:0] item_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > ivec_pkg::CAP_W) ? CW : ivec_pkg::CAP_W;

	// Request registers
	logic [ivec_pkg::OPCODE_W-1:0] op_q;
	logic [ivec_pkg::IDX_W-1:0]    idx_q;
	logic [DATA_WIDTH-1:0]         val_q;

	// Architectural state
	logic [ivec_pkg::CAP_W-1:0] capacity_q;
	logic [CW-1:0]              count_q;
	logic [DATA_WIDTH-1:0]      mem_q [DEPTH];

	// Read and shift pipeline
	logic [DATA_WIDTH-1:0] rdata_s1;
	logic [AW-1:0]         da_s1;
	logic                  pend_s1;
	logic [AW-1:0]         rp_q;
	logic [DATA_WIDTH-1:0] rd_q;
	ivec_pkg::ivec_status_t status_q;

	// Result register
	logic                   out_valid_q;
	ivec_pkg::ivec_status_t out_status_q;
	logic [DATA_WIDTH-1:0]  out_rd_q;
	logic [CW-1:0]          out_cnt_q;

	// Derived values
	logic [LW-1:0] cnt_l, idx_l, cap_l, lim_l;
	logic [CW-1:0] cnt_m1;
	logic          full, bad_idx, empty, dir_down;
	ivec_pkg::ivec_status_t st_next;
	logic [AW-1:0] top_addr, idx_addr, rd_addr, wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  mem_wr, mem_rd;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ivec_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			idx_q <= index;
			val_q <= DATA_WIDTH'(value);
		end
	end

	// Limit, bounds and status checks
	always_comb begin
		cnt_l    = LW'(count_q);
		idx_l    = LW'(idx_q);
		cap_l    = LW'(capacity_q);
		lim_l    = (cap_l > LW'(DEPTH)) ? LW'(DEPTH) : cap_l;
		cnt_m1   = count_q - CW'(1);
		full     = cnt_l >= lim_l;
		bad_idx  = idx_l >= cnt_l;
		empty    = (count_q == '0);
		dir_down = (op_q == ivec_pkg::OP_INSERT);
		unique case (op_q) inside
			ivec_pkg::OP_PUSH:
				st_next = full ? ivec_pkg::ST_FULL : ivec_pkg::ST_OK;
			ivec_pkg::OP_POP:
				st_next = empty ? ivec_pkg::ST_EMPTY : ivec_pkg::ST_OK;
			ivec_pkg::OP_GET, ivec_pkg::OP_SET, ivec_pkg::OP_REMOVE:
				st_next = bad_idx ? ivec_pkg::ST_BADIDX : ivec_pkg::ST_OK;
			ivec_pkg::OP_INSERT:
				st_next = bad_idx ? ivec_pkg::ST_BADIDX :
					(full ? ivec_pkg::ST_FULL : ivec_pkg::ST_OK);
			default:
				st_next = ivec_pkg::ST_OK;
		endcase
	end

	// Status back to the controller
	always_comb begin
		sts.op         = op_q;
		sts.fail       = (st_next != ivec_pkg::ST_OK);
		sts.shift_last = dir_down ? (rp_q == AW'(idx_q)) : (rp_q == AW'(cnt_m1));
		sts.rem_none   = ((idx_l + LW'(1)) == cnt_l);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Memory address and data selection
	always_comb begin
		top_addr = AW'(count_q);
		idx_addr = AW'(idx_q);
		mem_rd   = cmd.rd_en || cmd.shift;
		if (cmd.shift) begin
			rd_addr = rp_q;
		end else if (cmd.rd_sel == ivec_pkg::RD_TOP) begin
			rd_addr = AW'(cnt_m1);
		end else begin
			rd_addr = idx_addr;
		end
		mem_wr = pend_s1 || cmd.wr_en;
		if (pend_s1) begin
			wr_addr = da_s1;
			wr_data = rdata_s1;
		end else begin
			case (cmd.wr_sel)
				ivec_pkg::WR_TOP: begin
					wr_addr = top_addr;
					wr_data = val_q;
				end
				ivec_pkg::WR_IDX: begin
					wr_addr = idx_addr;
					wr_data = val_q;
				end
				ivec_pkg::WR_LAST: begin
					wr_addr = AW'(cnt_m1);
					wr_data = '0;
				end
				default: begin
					wr_addr = idx_addr;
					wr_data = val_q;
				end
			endcase
		end
	end

	// Element memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (mem_rd) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// Shift pointer and pending write address
	always_ff @(posedge clk) begin
		if (cmd.ptr_init) begin
			rp_q <= (cmd.ptr_sel == ivec_pkg::PTR_TOP) ? AW'(cnt_m1) : (idx_addr + AW'(1));
		end else if (cmd.shift) begin
			rp_q <= dir_down ? (rp_q - AW'(1)) : (rp_q + AW'(1));
		end
		if (cmd.shift) begin
			da_s1 <= dir_down ? (rp_q + AW'(1)) : (rp_q - AW'(1));
		end
	end

	// Flag a shift read whose write lands next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.shift;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= cnt_m1;
		end
	end

	// Read word and status of the current request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= '0;
		end else if (cmd.rd_cap) begin
			rd_q <= rdata_s1;
		end
		if (cmd.stat_en) begin
			status_q <= st_next;
		end
	end

	// Result register: hold until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_rd_q     <= rd_q;
			out_cnt_q    <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = ivec_pkg::VALUE_W'(out_rd_q);
	assign item_count = ivec_pkg::COUNT_W'(out_cnt_q);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !cmd.wr_en)
		else $error("shift write collides with a command write");

	a_cnt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !cmd.cnt_dec)
		else $error("count incremented and decremented together");
`endif

endmodule

@@ rtl/core/ivec_ctrl.sv @@
// Controller of the indexed integer vector engine: sequences each request
// through check, memory access, shift and result hand-off.
// Depends on ivec_pkg; drives ivec_datapath through command signals.
module ivec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ivec_pkg::ivec_sts_t sts,
	output ivec_pkg::ivec_cmd_t cmd
);

	ivec_pkg::ivec_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ivec_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ivec_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ivec_pkg::S_CHECK;
				end
			end
			ivec_pkg::S_CHECK: begin
				cmd.stat_en = 1'b1;
				state_d     = ivec_pkg::S_DONE;
				if (!sts.fail) begin
					unique case (sts.op)
						ivec_pkg::OP_PUSH: begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = ivec_pkg::WR_TOP;
							cmd.cnt_inc = 1'b1;
						end
						ivec_pkg::OP_POP: begin
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = ivec_pkg::RD_TOP;
							cmd.cnt_dec = 1'b1;
							state_d     = ivec_pkg::S_RDCAP;
						end
						ivec_pkg::OP_GET: begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = ivec_pkg::RD_IDX;
							state_d    = ivec_pkg::S_RDCAP;
						end
						ivec_pkg::OP_SET: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = ivec_pkg::WR_IDX;
						end
						ivec_pkg::OP_INSERT: begin
							cmd.ptr_init = 1'b1;
							cmd.ptr_sel  = ivec_pkg::PTR_TOP;
							state_d      = ivec_pkg::S_SHIFT;
						end
						ivec_pkg::OP_REMOVE: begin
							cmd.rd_en    = 1'b1;
							cmd.rd_sel   = ivec_pkg::RD_IDX;
							cmd.ptr_init = 1'b1;
							cmd.ptr_sel  = ivec_pkg::PTR_NEXT;
							state_d      = ivec_pkg::S_RDCAP;
						end
						default: begin
							state_d = ivec_pkg::S_DONE;
						end
					endcase
				end
			end
			ivec_pkg::S_RDCAP: begin
				cmd.rd_cap = 1'b1;
				if (sts.op == ivec_pkg::OP_REMOVE) begin
					state_d = sts.rem_none ? ivec_pkg::S_FIN : ivec_pkg::S_SHIFT;
				end else begin
					state_d = ivec_pkg::S_DONE;
				end
			end
			ivec_pkg::S_SHIFT: begin
				// Move one entry per cycle; each write trails its read through a register
				cmd.shift = 1'b1;
				if (sts.shift_last) begin
					state_d = ivec_pkg::S_DRAIN;
				end
			end
			ivec_pkg::S_DRAIN: begin
				state_d = ivec_pkg::S_FIN;
			end
			ivec_pkg::S_FIN: begin
				cmd.wr_en = 1'b1;
				if (sts.op == ivec_pkg::OP_INSERT) begin
					cmd.wr_sel  = ivec_pkg::WR_IDX;
					cmd.cnt_inc = 1'b1;
				end else begin
					cmd.wr_sel  = ivec_pkg::WR_LAST;
					cmd.cnt_dec = 1'b1;
				end
				state_d = ivec_pkg::S_DONE;
			end
			ivec_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ivec_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ivec_pkg::S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while one is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten before it was taken");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ivec_pkg::S_DRAIN) |-> $past(cmd.shift))
		else $error("drain entered without a pending shift read");
`endif

endmodule

@@ sim/tb_indexed_int_vector_engine.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_int_vector_engine: directed and random
// requests with random gaps and output stalls, checked against a shadow array.
// Depends on ivec_pkg and the engine RTL.
module tb_indexed_int_vector_engine;

	localparam int VEC_DEPTH   = 1024;
	localparam int MAX_GAP     = 11;
	localparam int QUIET_LIMIT = 6000;
	localparam int SHIFT_FILL  = 120;

	// Opcodes the engine leaves undefined; they must do nothing
	localparam logic [ivec_pkg::OPCODE_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [ivec_pkg::OPCODE_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct {
		ivec_pkg::ivec_status_t        status;
		logic [ivec_pkg::VALUE_W-1:0]  read_value;
		logic [ivec_pkg::COUNT_W-1:0]  item_count;
	} vec_result_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic        [ivec_pkg::CAP_W-1:0]    cfg_wdata = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic        [ivec_pkg::OPCODE_W-1:0] opcode = '0;
	logic        [ivec_pkg::IDX_W-1:0]    index = '0;
	logic signed [ivec_pkg::VALUE_W-1:0]  value = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic        [ivec_pkg::STATUS_W-1:0] status;
	logic signed [ivec_pkg::VALUE_W-1:0]  read_value;
	logic        [ivec_pkg::COUNT_W-1:0]  item_count;

	// Shadow copy of the engine state
	logic [ivec_pkg::VALUE_W-1:0] vec_words [VEC_DEPTH];
	int unsigned                  vec_len = 0;
	logic [ivec_pkg::CAP_W-1:0]   vec_cap = ivec_pkg::CAP_RESET;

	vec_result_t pending_results[$];
	int          error_count = 0;
	bit          idle_on = 1'b1;
	int          hold_request = 0;

	always #6 clk = ~clk;

	indexed_int_vector_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.item_count (item_count)
	);

	// Apply one request to the shadow array and return the result it gives
	function automatic vec_result_t predict_vector_op(
			input logic [ivec_pkg::OPCODE_W-1:0] op,
			input logic [ivec_pkg::IDX_W-1:0] idx,
			input logic [ivec_pkg::VALUE_W-1:0] val);
		vec_result_t r;
		int unsigned lim;
		int unsigned i;
		lim = (vec_cap > VEC_DEPTH) ? VEC_DEPTH : vec_cap;
		r.status = ivec_pkg::ST_OK;
		r.read_value = '0;
		case (op)
			ivec_pkg::OP_PUSH: begin
				if (vec_len >= lim) begin
					r.status = ivec_pkg::ST_FULL;
				end else begin
					vec_words[vec_len] = val;
					vec_len++;
				end
			end
			ivec_pkg::OP_POP: begin
				if (vec_len == 0) begin
					r.status = ivec_pkg::ST_EMPTY;
				end else begin
					vec_len--;
					r.read_value = vec_words[vec_len];
				end
			end
			ivec_pkg::OP_GET: begin
				if (idx >= vec_len)
					r.status = ivec_pkg::ST_BADIDX;
				else
					r.read_value = vec_words[idx];
			end
			ivec_pkg::OP_SET: begin
				if (idx >= vec_len)
					r.status = ivec_pkg::ST_BADIDX;
				else
					vec_words[idx] = val;
			end
			ivec_pkg::OP_INSERT: begin
				// index check wins over the full check
				if (idx >= vec_len) begin
					r.status = ivec_pkg::ST_BADIDX;
				end else if (vec_len >= lim) begin
					r.status = ivec_pkg::ST_FULL;
				end else begin
					for (i = vec_len; i > idx; i--)
						vec_words[i] = vec_words[i - 1];
					vec_words[idx] = val;
					vec_len++;
				end
			end
			ivec_pkg::OP_REMOVE: begin
				if (idx >= vec_len) begin
					r.status = ivec_pkg::ST_BADIDX;
				end else begin
					r.read_value = vec_words[idx];
					for (i = idx; i + 1 < vec_len; i++)
						vec_words[i] = vec_words[i + 1];
					vec_words[vec_len - 1] = '0;
					vec_len--;
				end
			end
			default: ;
		endcase
		r.item_count = ivec_pkg::COUNT_W'(vec_len);
		return r;
	endfunction

	// Offer one request, after a random gap while idle_on is set, and hold it until accepted
	task automatic send_request(input logic [ivec_pkg::OPCODE_W-1:0] op,
			input logic [ivec_pkg::IDX_W-1:0] idx,
			input logic [ivec_pkg::VALUE_W-1:0] val);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		index <= idx;
		value <= val;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_vector_op(op, idx, val));
	endtask

	// Drop the request line and wait for every outstanding result
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [ivec_pkg::CAP_W-1:0] cap);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		vec_cap = cap;
	endtask

	// Mostly valid indexes, some at the end and some anywhere; count kept short
	task automatic send_random_request();
		int pick;
		logic [ivec_pkg::OPCODE_W-1:0] op;
		logic [ivec_pkg::IDX_W-1:0]    idx;
		logic [ivec_pkg::VALUE_W-1:0]  val;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			op = pick[0] ? OP_SPARE7 : OP_SPARE6;
		else if (pick < 28)
			op = (vec_len > 40) ? ivec_pkg::OP_POP : ivec_pkg::OP_PUSH;
		else if (pick < 42)
			op = ivec_pkg::OP_POP;
		else if (pick < 60)
			op = ivec_pkg::OP_GET;
		else if (pick < 76)
			op = ivec_pkg::OP_SET;
		else if (pick < 90)
			op = (vec_len > 40) ? ivec_pkg::OP_REMOVE : ivec_pkg::OP_INSERT;
		else
			op = ivec_pkg::OP_REMOVE;
		case ($urandom_range(0, 9))
			0: idx = ivec_pkg::IDX_W'($urandom_range(0, VEC_DEPTH - 1));
			1: idx = ivec_pkg::IDX_W'(vec_len);
			default: idx = (vec_len > 0) ?
				ivec_pkg::IDX_W'($urandom_range(0, vec_len - 1)) :
				ivec_pkg::IDX_W'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: val = 32'h8000_0000;
			1: val = 32'h7FFF_FFFF;
			2: val = '1;
			3: val = '0;
			default: val = $urandom;
		endcase
		if ($urandom_range(0, 29) == 0)
			idle_on = !idle_on;
		send_request(op, idx, val);
	endtask

	// Every operation but push on an empty array, plus the unused opcodes
	task automatic test_empty_array();
		send_request(ivec_pkg::OP_POP, '0, '0);
		send_request(ivec_pkg::OP_GET, '0, '0);
		send_request(ivec_pkg::OP_SET, 10'd1023, '1);
		send_request(ivec_pkg::OP_INSERT, '0, 32'h1);
		send_request(ivec_pkg::OP_REMOVE, 10'd1023, '0);
		send_request(OP_SPARE6, '0, '0);
		send_request(OP_SPARE7, 10'd1023, '1);
	endtask

	// Value extremes, insert and remove at both ends, refused insert past the end
	task automatic test_basic_ops();
		send_request(ivec_pkg::OP_PUSH, '0, 32'h8000_0000);
		send_request(ivec_pkg::OP_PUSH, '0, 32'h7FFF_FFFF);
		send_request(ivec_pkg::OP_PUSH, '0, '0);
		send_request(ivec_pkg::OP_PUSH, '0, '1);
		send_request(ivec_pkg::OP_GET, 10'd0, '0);
		send_request(ivec_pkg::OP_GET, 10'd3, '0);
		send_request(ivec_pkg::OP_SET, 10'd2, 32'h1234_5678);
		send_request(ivec_pkg::OP_INSERT, 10'd0, 32'hA5A5_A5A5);
		send_request(ivec_pkg::OP_INSERT, ivec_pkg::IDX_W'(vec_len - 1), 32'h5A5A_5A5A);
		send_request(ivec_pkg::OP_INSERT, ivec_pkg::IDX_W'(vec_len), 32'h0000_0001);
		send_request(ivec_pkg::OP_REMOVE, 10'd0, '0);
		send_request(ivec_pkg::OP_REMOVE, ivec_pkg::IDX_W'(vec_len - 1), '0);
		send_request(ivec_pkg::OP_POP, '0, '0);
	endtask

	// Zero capacity, and capacity lowered below the current count
	task automatic test_capacity_limits();
		write_capacity(11'd0);
		send_request(ivec_pkg::OP_PUSH, '0, 32'h1);
		send_request(ivec_pkg::OP_INSERT, '0, 32'h2);
		write_capacity(11'd1);
		send_request(ivec_pkg::OP_PUSH, '0, 32'h3);
		while (vec_len > 0) send_request(ivec_pkg::OP_POP, '0, '0);
		send_request(ivec_pkg::OP_PUSH, '0, 32'hCAFE_0004);
		send_request(ivec_pkg::OP_PUSH, '0, 32'h5);
		write_capacity(ivec_pkg::CAP_RESET);
	endtask

	task automatic test_random_traffic();
		write_capacity(ivec_pkg::CAP_RESET);
		repeat (60) send_random_request();
		write_capacity(11'd8);
		repeat (40) send_random_request();
		write_capacity(11'd3);
		repeat (30) send_random_request();
		write_capacity(11'd2047);
		repeat (40) send_random_request();
		write_capacity(11'd1);
		repeat (20) send_random_request();
		write_capacity(ivec_pkg::CAP_RESET);
		repeat (40) send_random_request();
	endtask

	// Hold the output off so the engine backs up and drain, then a gapped burst
	task automatic test_output_holdoff();
		idle_on = 1'b0;
		hold_request = 400;
		repeat (12) send_random_request();
		wait_until_drained();
		idle_on = 1'b1;
		repeat (12) send_random_request();
		wait_until_drained();
	endtask

	// Grow the array with capacity above DEPTH, then shift across all of it
	task automatic test_long_shifts();
		write_capacity(11'd2047);
		idle_on = 1'b0;
		while (vec_len < SHIFT_FILL)
			send_request(ivec_pkg::OP_PUSH, ivec_pkg::IDX_W'($urandom), $urandom);
		send_request(ivec_pkg::OP_INSERT, 10'd0, 32'h2);
		send_request(ivec_pkg::OP_GET, ivec_pkg::IDX_W'(vec_len - 1), '0);
		send_request(ivec_pkg::OP_SET, ivec_pkg::IDX_W'(vec_len - 1), 32'h8000_0001);
		send_request(ivec_pkg::OP_REMOVE, 10'd0, '0);
		send_request(ivec_pkg::OP_INSERT, 10'd0, 32'hFFFF_0000);
		send_request(ivec_pkg::OP_REMOVE, 10'd0, '0);
		idle_on = 1'b1;
		wait_until_drained();
	endtask

	// Result sink: random stall per result while idle_on, plus a long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (out_valid && out_ready)
				stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		vec_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d read_value %h item_count %0d",
					status, read_value, item_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, read_value);
					error_count++;
				end
				if (item_count !== want.item_count) begin
					$error("item_count: expected %0d, got %0d", want.item_count, item_count);
					error_count++;
				end
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_array();
		test_basic_ops();
		test_capacity_limits();
		test_random_traffic();
		test_output_holdoff();
		test_long_shifts();
		wait_until_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ indexed_int_vector_engine.f @@
rtl/core/ivec_pkg.sv
rtl/core/ivec_datapath.sv
rtl/core/ivec_ctrl.sv
rtl/core/indexed_int_vector_engine.sv
sim/tb_indexed_int_vector_engine.sv
